// ----- hdl/ste_pkg.sv -----
// Shared constants for the Sobel threshold edge line block.
// Field widths, register indexes and output codes; no dependencies.
`default_nettype none

package ste_pkg;

    // Default upper bound on the line width.
    localparam int MAX_WIDTH_DEFAULT = 4096;

    // Payload field widths.
    localparam int PIX_W = 8;
    localparam int ROW_W = 12;
    localparam int COL_W = 12;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_W       = 13;

    // Gradient magnitude arithmetic.
    localparam int GRAD_W = 10;
    localparam int THR2_W = 16;
    localparam int MAG_W  = 2 * GRAD_W + 1;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // Reset values of the registers.
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // Output pixel codes.
    localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

endpackage : ste_pkg

`default_nettype wire

// ----- hdl/ste_stream_if.sv -----
// Stream interfaces for the pixel column input and the edge pixel output.
// Depends on ste_pkg for the field widths.
`default_nettype none

interface ste_pixel_if;
    import ste_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] top_pixel;
    logic [PIX_W-1:0] middle_pixel;
    logic [PIX_W-1:0] bottom_pixel;
    logic [ROW_W-1:0] row_index;

    modport source (output valid, top_pixel, middle_pixel, bottom_pixel, row_index,
                    input ready);
    modport sink   (input valid, top_pixel, middle_pixel, bottom_pixel, row_index,
                    output ready);
endinterface : ste_pixel_if

interface ste_edge_if;
    import ste_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_value;
    logic [COL_W-1:0] column_index;
    logic             line_end;

    modport source  (output valid, edge_value, column_index, line_end, input ready);
    modport sink    (input valid, edge_value, column_index, line_end, output ready);
    modport monitor (input valid, ready, edge_value, column_index, line_end);
endinterface : ste_edge_if

`default_nettype wire

// ----- hdl/ste_magnitude.sv -----
// Squared gradient magnitude compared against the squared threshold.
// Depends on ste_pkg for the gradient and threshold widths.
`default_nettype none

module ste_magnitude (
    input  logic [ste_pkg::GRAD_W-1:0] gx_abs,
    input  logic [ste_pkg::GRAD_W-1:0] gy_abs,
    input  logic [ste_pkg::THR2_W-1:0] threshold_sq,
    output logic                       is_edge
);
    import ste_pkg::*;

    logic [2*GRAD_W-1:0] gx_sq;
    logic [2*GRAD_W-1:0] gy_sq;
    logic [MAG_W-1:0]    mag_sq;

    // Two narrow squares in parallel, one add and one compare.
    assign gx_sq   = (2*GRAD_W)'(gx_abs) * (2*GRAD_W)'(gx_abs);
    assign gy_sq   = (2*GRAD_W)'(gy_abs) * (2*GRAD_W)'(gy_abs);
    assign mag_sq  = MAG_W'(gx_sq) + MAG_W'(gy_sq);
    assign is_edge = (mag_sq >= MAG_W'(threshold_sq));

endmodule : ste_magnitude

`default_nettype wire

// ----- hdl/sobel_threshold_edge_line.sv -----
// Top level of the Sobel threshold edge detector, fed one pixel column per word.
// Depends on ste_pkg, ste_stream_if and ste_magnitude.
//
//   Channel      Dir   Handshake     Word contents
//   pixels       in    valid/ready   top, middle, bottom pixel, row index
//   edges        out   valid/ready   edge value, column index, line end
//   cfg_*        in    write enable  register index, write data
//
// One column word is accepted per cycle while the output is not stalled; its result
// words pass through the stage register into the output register and are offered there.
// A column that ends a line also gives a line end word and holds the input until it
// is loaded, since the output register moves at most one word per cycle.
// Reset is asynchronous and active low; it clears the window, the column counter,
// the threshold, the phase and both valid flags, and loads the default width and height.
// A stall on the output holds the stage register and backs up into pixels.ready.
`default_nettype none

module sobel_threshold_edge_line #(
    parameter int MAX_WIDTH = ste_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ste_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ste_pkg::CFG_DATA_W-1:0]  cfg_data,
    ste_pixel_if.sink                       pixels,
    ste_edge_if.source                      edges
);
    import ste_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int HW = DIM_W + 1;

    // Weighted sum of three pixels, the middle one counted twice.
    function automatic logic [GRAD_W-1:0] tap_sum(input logic [PIX_W-1:0] p0,
                                                  input logic [PIX_W-1:0] p1,
                                                  input logic [PIX_W-1:0] p2);
        tap_sum = GRAD_W'(p0) + GRAD_W'({p1, 1'b0}) + GRAD_W'(p2);
    endfunction

    function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] a,
                                                   input logic [GRAD_W-1:0] b);
        abs_diff = (a >= b) ? a - b : b - a;
    endfunction

    // Stage register contents for one accepted column.
    typedef struct packed {
        logic              emit_prev;
        logic              is_last;
        logic              border;
        logic [GRAD_W-1:0] gx_abs;
        logic [GRAD_W-1:0] gy_abs;
        logic [CW-1:0]     prev_col;
        logic [CW-1:0]     this_col;
    } stage_t;

    // Configuration registers.
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [THR2_W-1:0] thr2_reg;

    // Window and column counter.
    logic [PIX_W-1:0] win_reg [6];
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;

    // Stage and output registers.
    stage_t           stage_reg;
    stage_t           stage_next;
    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic             phase_reg;
    logic             phase_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] out_edge_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_last_reg;

    logic [LW-1:0]    eff_width;
    logic [LW-1:0]    width_ext;
    logic [LW-1:0]    col_ext;
    logic [LW-1:0]    prev_ext;
    logic [HW-1:0]    row_ext;
    logic             col_last;
    logic             col_border;
    logic             row_border;
    logic             accept;
    logic             produces;
    logic             send_prev;
    logic             has_more;
    logic             out_load;
    logic             stage_done;
    logic             is_edge;

    // Effective line width: zero counts as one, clipped at MAX_WIDTH.
    always_comb
    begin
        width_ext = LW'(width_reg);
        if (width_ext == '0)
            eff_width = LW'(1);
        else if (width_ext > LW'(MAX_WIDTH))
            eff_width = LW'(MAX_WIDTH);
        else
            eff_width = width_ext;
    end

    // Position tests for the arriving column and the one before it.
    assign col_ext    = LW'(col_reg);
    assign prev_ext   = LW'(col_reg - CW'(1));
    assign row_ext    = HW'(pixels.row_index);
    assign col_last   = (col_ext + LW'(1)) >= eff_width;
    assign col_border = (prev_ext < LW'(2)) || ((prev_ext + LW'(2)) >= eff_width);
    assign row_border = (row_ext < HW'(2)) || ((row_ext + HW'(2)) >= HW'(height_reg));
    assign produces   = (col_reg != '0) || col_last;
    assign col_next   = col_last ? '0 : col_reg + CW'(1);

    // Gradients over columns k-2 (entries 0..2), k-1 (3..5) and the new one.
    always_comb
    begin
        stage_next.emit_prev = (col_reg != '0);
        stage_next.is_last   = col_last;
        stage_next.border    = col_border || row_border;
        stage_next.gx_abs    = abs_diff(
            tap_sum(pixels.top_pixel, pixels.middle_pixel, pixels.bottom_pixel),
            tap_sum(win_reg[0], win_reg[1], win_reg[2]));
        stage_next.gy_abs    = abs_diff(
            tap_sum(win_reg[0], win_reg[3], pixels.top_pixel),
            tap_sum(win_reg[2], win_reg[5], pixels.bottom_pixel));
        stage_next.prev_col  = col_reg - CW'(1);
        stage_next.this_col  = col_reg;
    end

    ste_magnitude u_magnitude (
        .gx_abs       (stage_reg.gx_abs),
        .gy_abs       (stage_reg.gy_abs),
        .threshold_sq (thr2_reg),
        .is_edge      (is_edge)
    );

    // Word selection out of the stage: result for k-1 first, then line end.
    assign send_prev  = stage_reg.emit_prev && !phase_reg;
    assign has_more   = send_prev && stage_reg.is_last;
    assign out_load   = stage_valid_reg && (!out_valid_reg || edges.ready);
    assign stage_done = out_load && !has_more;
    assign pixels.ready = !stage_valid_reg || stage_done;
    assign accept     = pixels.valid && pixels.ready;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = produces;
            phase_next       = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg && !stage_done;
            phase_next       = phase_reg || (out_load && has_more);
        end
        if (out_load)
            out_valid_next = 1'b1;
        else if (edges.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Configuration writes; the threshold is kept squared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
            thr2_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                REG_EDGE_THRESHOLD: thr2_reg   <= THR2_W'(cfg_data[PIX_W-1:0])
                                                  * THR2_W'(cfg_data[PIX_W-1:0]);
                default:            ;
            endcase
        end
    end

    // Window shift and column counter, advanced on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= pixels.top_pixel;
            win_reg[4] <= pixels.middle_pixel;
            win_reg[5] <= pixels.bottom_pixel;
            col_reg    <= col_next;
        end
    end

    // Control flags of the stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            phase_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
        if (out_load)
        begin
            if (send_prev)
            begin
                out_edge_reg <= (!stage_reg.border && is_edge) ? EDGE_ON : EDGE_OFF;
                out_col_reg  <= COL_W'(stage_reg.prev_col);
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_edge_reg <= EDGE_OFF;
                out_col_reg  <= COL_W'(stage_reg.this_col);
                out_last_reg <= 1'b1;
            end
        end
    end

    assign edges.valid        = out_valid_reg;
    assign edges.edge_value   = out_edge_reg;
    assign edges.column_index = out_col_reg;
    assign edges.line_end     = out_last_reg;

endmodule : sobel_threshold_edge_line

`default_nettype wire

// ----- hdl/ste_checker.sv -----
// Port-level assertions on the edge output of the Sobel threshold block.
// Depends on ste_pkg and ste_stream_if; bound to sobel_threshold_edge_line.
`default_nettype none

module ste_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [ste_pkg::PIX_W-1:0] edge_value,
    input  logic [ste_pkg::COL_W-1:0] column_index,
    input  logic                     line_end
);
    import ste_pkg::*;

    // A word on offer stays on offer until it is taken.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("edge word withdrawn while stalled");

    // A stalled word keeps its contents.
    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(edge_value)
            && $stable(column_index) && $stable(line_end))
        else $error("edge word changed while stalled");

    // Every pixel is either marked or cleared, nothing in between.
    a_binary_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (edge_value == EDGE_ON) || (edge_value == EDGE_OFF))
        else $error("edge value neither on nor off");

    // The last pixel of a line lies on the right border and is never an edge.
    a_line_end_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> edge_value == EDGE_OFF)
        else $error("line end pixel marked as edge");

endmodule : ste_checker

bind sobel_threshold_edge_line ste_checker u_ste_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (edges.valid),
    .out_ready    (edges.ready),
    .edge_value   (edges.edge_value),
    .column_index (edges.column_index),
    .line_end     (edges.line_end)
);

`default_nettype wire
